[rtl/spike_filtered_mean_stddev_macros.svh]
// Assertion helpers for the spike-filtered mean / stddev block.
// Both expect clk_i and rst_ni in the scope where they are used.
`ifndef SPIKE_FILTERED_MEAN_STDDEV_MACROS_SVH
`define SPIKE_FILTERED_MEAN_STDDEV_MACROS_SVH

// same-cycle implication
`define SFMS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SFMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/sfms_pkg.sv]
`default_nettype none

package sfms_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned ThrW    = 16;
  localparam int unsigned SumW    = 33;
  localparam int unsigned SqW     = 48;
  localparam int unsigned CntW    = 17;

  localparam logic [CntW-1:0] MaxSamples = CntW'(65536);
  // 2.0 in Q8.8
  localparam logic [ThrW-1:0] ThrReset   = ThrW'(512);

  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  localparam int unsigned DvdW     = 64;
  localparam int unsigned DvsW     = 32;
  localparam int unsigned DivSteps = DvdW;
  localparam int unsigned DivCntW  = $clog2(DivSteps + 1);

  localparam logic [DvdW-1:0] SqrtTop = DvdW'(64'h4000_0000_0000_0000);

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      last_sample;
  } in_t;

  typedef struct packed {
    logic signed [15:0] mean_value;
    logic [15:0]        std_deviation;
    logic [CntW-1:0]    kept_count;
    logic               overflow_seen;
  } res_t;

  // totals of one finished set
  typedef struct packed {
    logic signed [SumW-1:0] sum;
    logic [SqW-1:0]         sumsq;
    logic [CntW-1:0]        count;
    logic                   ovf;
  } snap_t;

  typedef struct packed {
    logic            start;
    logic [DvdW-1:0] dividend;
    logic [DvsW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DvdW-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

[rtl/sfms_front.sv]
`default_nettype none

module sfms_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sfms_pkg::ThrW-1:0]       cfg_wdata_i,
  input  logic                            push_i,
  output logic                            full_o,
  input  sfms_pkg::in_t                   item_i,
  output logic                            snap_push_o,
  output sfms_pkg::snap_t                 snap_o,
  input  logic                            snap_full_i
);

  localparam int unsigned SW = sfms_pkg::SampleW;

  logic [sfms_pkg::ThrW-1:0] thr_q;
  logic [SW-1:0]             last_kept_q;
  logic                      started_q;

  logic                      s1_v_q;
  logic                      s1_keep_q;
  logic                      s1_last_q;
  logic [SW-1:0]             s1_sample_q;

  logic [sfms_pkg::SumW-1:0] sum_q, sum_d;
  logic [sfms_pkg::SqW-1:0]  sumsq_q, sumsq_d;
  logic [sfms_pkg::CntW-1:0] cnt_q, cnt_d;
  logic                      ovf_q, ovf_d;

  logic [SW:0]               diff;
  logic [SW:0]               abs_diff;
  logic                      keep;
  logic                      in_acc;
  logic                      s1_adv;
  logic                      consume;
  logic                      room;
  logic                      add;
  logic [SW-1:0]             mag;
  logic [2*SW-1:0]           sq;

  // spike filter against the last kept sample
  assign diff     = {item_i.sample[SW-1], item_i.sample} - {last_kept_q[SW-1], last_kept_q};
  assign abs_diff = diff[SW] ? ((SW+1)'(0) - diff) : diff;
  assign keep     = !started_q || (abs_diff < {1'b0, thr_q});

  // hold the last beat of a set until the queue has room
  assign s1_adv  = !s1_last_q || !snap_full_i;
  assign consume = s1_v_q && s1_adv;
  assign full_o  = s1_v_q && !s1_adv;
  assign in_acc  = push_i && !full_o;

  assign room = (cnt_q != sfms_pkg::MaxSamples);
  assign add  = s1_keep_q && room;
  assign mag  = s1_sample_q[SW-1] ? (SW'(0) - s1_sample_q) : s1_sample_q;
  assign sq   = mag * mag;

  always_comb begin
    sum_d   = sum_q;
    sumsq_d = sumsq_q;
    cnt_d   = cnt_q;
    ovf_d   = ovf_q | (s1_keep_q && !room);
    if (add) begin
      sum_d   = sum_q + {{(sfms_pkg::SumW-SW){s1_sample_q[SW-1]}}, s1_sample_q};
      sumsq_d = sumsq_q + sfms_pkg::SqW'(sq);
      cnt_d   = cnt_q + 1'b1;
    end
  end

  assign snap_push_o  = consume && s1_last_q;
  assign snap_o.sum   = sum_d;
  assign snap_o.sumsq = sumsq_d;
  assign snap_o.count = cnt_d;
  assign snap_o.ovf   = ovf_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= sfms_pkg::ThrReset;
      started_q <= 1'b0;
      s1_v_q    <= 1'b0;
      sum_q     <= '0;
      sumsq_q   <= '0;
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        started_q <= !item_i.last_sample;
        s1_v_q    <= 1'b1;
      end else if (consume) begin
        s1_v_q <= 1'b0;
      end
      if (consume) begin
        if (s1_last_q) begin
          sum_q   <= '0;
          sumsq_q <= '0;
          cnt_q   <= '0;
          ovf_q   <= 1'b0;
        end else begin
          sum_q   <= sum_d;
          sumsq_q <= sumsq_d;
          cnt_q   <= cnt_d;
          ovf_q   <= ovf_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_kept_q <= '0;
    end else if (in_acc && keep) begin
      last_kept_q <= item_i.sample;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_sample_q <= item_i.sample;
      s1_keep_q   <= keep;
      s1_last_q   <= item_i.last_sample;
    end
  end

endmodule

`default_nettype wire

[rtl/sfms_fifo.sv]
`default_nettype none

module sfms_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sfms_pkg::snap_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output sfms_pkg::snap_t data_o
);

  localparam int unsigned PW = sfms_pkg::FifoPtrW;
  localparam int unsigned CW = sfms_pkg::FifoCntW;
  localparam logic [PW-1:0] LastPtr = PW'(sfms_pkg::FifoDepth - 1);
  localparam logic [CW-1:0] FullCnt = CW'(sfms_pkg::FifoDepth);

  sfms_pkg::snap_t   entry_q [sfms_pkg::FifoDepth];
  logic [PW-1:0]     wr_ptr_q;
  logic [PW-1:0]     rd_ptr_q;
  logic [CW-1:0]     cnt_q;
  logic              do_push;
  logic              do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

[rtl/sfms_div.sv]
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module sfms_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sfms_pkg::div_req_t req_i,
  output sfms_pkg::div_rsp_t rsp_o
);

  localparam int unsigned DW = sfms_pkg::DvdW;
  localparam int unsigned VW = sfms_pkg::DvsW;

  logic [sfms_pkg::DivCntW-1:0] cnt_q;
  logic                         done_q;
  logic [DW-1:0]                quo_q;
  logic [VW-1:0]                rem_q;
  logic [VW-1:0]                dvs_q;
  logic [VW:0]                  rem_sh;
  logic [VW:0]                  rem_sub;
  logic                         ge;

  assign rem_sh  = {rem_q, quo_q[DW-1]};
  assign ge      = (rem_sh >= {1'b0, dvs_q});
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        cnt_q <= sfms_pkg::DivCntW'(sfms_pkg::DivSteps);
      end else if (cnt_q != '0) begin
        cnt_q  <= cnt_q - 1'b1;
        done_q <= (cnt_q == sfms_pkg::DivCntW'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (cnt_q != '0) begin
      quo_q <= {quo_q[DW-2:0], ge};
      rem_q <= ge ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
    end
  end

endmodule

`default_nettype wire

[rtl/sfms_back.sv]
`default_nettype none

module sfms_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               snap_empty_i,
  input  sfms_pkg::snap_t    snap_i,
  output logic               snap_pop_o,
  output sfms_pkg::div_req_t div_req_o,
  input  sfms_pkg::div_rsp_t div_rsp_i,
  input  logic               pop_i,
  output logic               empty_o,
  output sfms_pkg::res_t     result_o
);

  localparam int unsigned CW = sfms_pkg::CntW;
  localparam int unsigned DW = sfms_pkg::DvdW;
  localparam int unsigned VW = sfms_pkg::DvsW;
  localparam int unsigned HW = 24;

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StMulLo = 4'd1;
  localparam logic [3:0] StMulHi = 4'd2;
  localparam logic [3:0] StSqr   = 4'd3;
  localparam logic [3:0] StDen   = 4'd4;
  localparam logic [3:0] StDivM  = 4'd5;
  localparam logic [3:0] StDivV  = 4'd6;
  localparam logic [3:0] StSqrt  = 4'd7;
  localparam logic [3:0] StOut   = 4'd8;

  logic [3:0]                state_q, state_d;
  logic                      res_v_q;
  sfms_pkg::res_t            res_q;

  logic                      neg_q;
  logic [31:0]               abs_q;
  logic [sfms_pkg::SqW-1:0]  sumsq_q;
  logic [CW-1:0]             n_q;
  logic                      ovf_q;
  logic [DW-1:0]             acc_q;
  logic [39:0]               prod_q;
  logic [DW-1:0]             num2_q;
  logic [DW-1:0]             num_q;
  logic [VW-1:0]             den_q;
  logic [15:0]               mean_q;
  logic [15:0]               sd_q;
  logic [DW-1:0]             x_q;
  logic [DW-1:0]             r_q;
  logic [DW-1:0]             bit_q;

  logic [sfms_pkg::SumW-1:0] neg_sum;
  logic [31:0]               abs_in;
  logic [39:0]               lo_prod;
  logic [39:0]               hi_prod;
  logic [DW-1:0]             sq_prod;
  logic [CW-1:0]             n_m1;
  logic [2*CW-1:0]           den_full;
  logic [DW-1:0]             r_plus;
  logic                      sq_take;
  logic [15:0]               q_lo;
  logic                      multi;
  logic                      out_free;

  assign neg_sum  = sfms_pkg::SumW'(0) - snap_i.sum;
  assign abs_in   = snap_i.sum[sfms_pkg::SumW-1] ? neg_sum[31:0] : snap_i.sum[31:0];
  assign lo_prod  = n_q * sumsq_q[HW-1:0];
  assign hi_prod  = n_q * sumsq_q[2*HW-1:HW];
  assign sq_prod  = abs_q * abs_q;
  assign n_m1     = n_q - 1'b1;
  assign den_full = n_q * n_m1;
  assign r_plus   = r_q + bit_q;
  assign sq_take  = (x_q >= r_plus);
  assign q_lo     = div_rsp_i.quotient[15:0];
  assign multi    = (n_q > CW'(1));
  assign out_free = !res_v_q || pop_i;

  assign snap_pop_o = (state_q == StIdle) && !snap_empty_i;

  // one divider serves the mean first, then the variance for sets of more than one sample
  always_comb begin
    div_req_o.start    = 1'b0;
    div_req_o.dividend = num_q;
    div_req_o.divisor  = den_q;
    if (state_q == StDen) begin
      div_req_o.start    = 1'b1;
      div_req_o.dividend = DW'(abs_q);
      div_req_o.divisor  = VW'(n_q);
    end else if (state_q == StDivM && div_rsp_i.done && multi) begin
      div_req_o.start = 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (!snap_empty_i) state_d = StMulLo;
      StMulLo: state_d = StMulHi;
      StMulHi: state_d = StSqr;
      StSqr:   state_d = StDen;
      StDen:   state_d = StDivM;
      StDivM: begin
        if (div_rsp_i.done) state_d = multi ? StDivV : StOut;
      end
      StDivV: begin
        if (div_rsp_i.done) state_d = StSqrt;
      end
      StSqrt: begin
        if (bit_q == '0) state_d = StOut;
      end
      StOut: begin
        if (out_free) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      res_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StOut && out_free) begin
        res_v_q <= 1'b1;
      end else if (pop_i) begin
        res_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        if (!snap_empty_i) begin
          neg_q   <= snap_i.sum[sfms_pkg::SumW-1];
          abs_q   <= abs_in;
          sumsq_q <= snap_i.sumsq;
          n_q     <= snap_i.count;
          ovf_q   <= snap_i.ovf;
        end
      end
      StMulLo: acc_q  <= DW'(lo_prod);
      StMulHi: prod_q <= hi_prod;
      StSqr: begin
        acc_q  <= acc_q + {prod_q[DW-HW-1:0], {HW{1'b0}}};
        num2_q <= sq_prod;
      end
      StDen: begin
        num_q <= (acc_q > num2_q) ? (acc_q - num2_q) : '0;
        den_q <= den_full[VW-1:0];
      end
      StDivM: begin
        if (div_rsp_i.done) begin
          if (n_q == '0) begin
            mean_q <= '0;
          end else begin
            mean_q <= neg_q ? (16'd0 - q_lo) : q_lo;
          end
          sd_q <= '0;
        end
      end
      StDivV: begin
        if (div_rsp_i.done) begin
          x_q   <= div_rsp_i.quotient;
          r_q   <= '0;
          bit_q <= sfms_pkg::SqrtTop;
        end
      end
      StSqrt: begin
        if (bit_q != '0) begin
          if (sq_take) begin
            x_q <= x_q - r_plus;
            r_q <= (r_q >> 1) + bit_q;
          end else begin
            r_q <= r_q >> 1;
          end
          bit_q <= bit_q >> 2;
        end else begin
          sd_q <= (r_q[DW-1:16] != '0) ? 16'hFFFF : r_q[15:0];
        end
      end
      StOut: begin
        if (out_free) begin
          res_q.mean_value    <= mean_q;
          res_q.std_deviation <= sd_q;
          res_q.kept_count    <= n_q;
          res_q.overflow_seen <= ovf_q;
        end
      end
      default: ;
    endcase
  end

  assign empty_o  = !res_v_q;
  assign result_o = res_q;

endmodule

`default_nettype wire

[rtl/spike_filtered_mean_stddev.sv]
// Throughput: one sample beat per cycle, save while full holds a set's last beat until the
// two-entry queue has room; that beat's totals then enter the queue, so intake runs on while
// the back end does the math. Each result takes two 64-step divisions (mean, then variance)
// and a 32-step square root; a one-sample set needs only the mean division. The back end
// takes a new set only from idle, one set at a time. Reset (rst_ni low, async) empties the
// queues, clears the totals and restores the jump threshold to 2.0.
`default_nettype none

module spike_filtered_mean_stddev (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [sfms_pkg::ThrW-1:0] cfg_wdata_i,
  input  logic                      push,
  output logic                      full,
  input  sfms_pkg::in_t             item_i,
  output logic                      empty,
  input  logic                      pop,
  output sfms_pkg::res_t            result_o
);

  logic               snap_push;
  logic               snap_full;
  logic               snap_pop;
  logic               snap_empty;
  sfms_pkg::snap_t    snap_in;
  sfms_pkg::snap_t    snap_out;
  sfms_pkg::div_req_t div_req;
  sfms_pkg::div_rsp_t div_rsp;

  sfms_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_i      (push),
    .full_o      (full),
    .item_i      (item_i),
    .snap_push_o (snap_push),
    .snap_o      (snap_in),
    .snap_full_i (snap_full)
  );

  sfms_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (snap_push),
    .data_i  (snap_in),
    .full_o  (snap_full),
    .pop_i   (snap_pop),
    .empty_o (snap_empty),
    .data_o  (snap_out)
  );

  sfms_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  sfms_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .snap_empty_i (snap_empty),
    .snap_i       (snap_out),
    .snap_pop_o   (snap_pop),
    .div_req_o    (div_req),
    .div_rsp_i    (div_rsp),
    .pop_i        (pop),
    .empty_o      (empty),
    .result_o     (result_o)
  );

endmodule

`default_nettype wire

[rtl/sfms_checker.sv]
`default_nettype none

`include "spike_filtered_mean_stddev_macros.svh"

module sfms_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           empty,
  input logic           pop,
  input sfms_pkg::res_t result_o
);

  // a waiting beat stays put until popped
  `SFMS_ASSERT_NEXT(a_res_hold, !empty && !pop, !empty && $stable(result_o), "result beat changed while waiting")

  `SFMS_ASSERT_IMPL(a_count_nz, !empty, result_o.kept_count != '0, "result with zero kept count")

  // samples are dropped for capacity only once the count is full
  `SFMS_ASSERT_IMPL(a_ovf_full, !empty && result_o.overflow_seen, result_o.kept_count == sfms_pkg::MaxSamples, "overflow flagged below capacity")

  `SFMS_ASSERT_IMPL(a_single_sd, !empty && result_o.kept_count == sfms_pkg::CntW'(1), result_o.std_deviation == '0, "nonzero deviation for a one-sample set")

endmodule

bind spike_filtered_mean_stddev sfms_checker u_sfms_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .empty    (empty),
  .pop      (pop),
  .result_o (result_o)
);

`default_nettype wire
